### design/chp_pkg.sv
// Shared types, codes and the type-tag decoder for the command header parser.
// Used by chp_step and command_header_parser; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package chp_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DEF = 65535;
    localparam int unsigned POS_W = 16;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Three-character type tags, first character in the top byte
    localparam logic [23:0] TAG_READVAR      = 24'h73524E;  // sRN
    localparam logic [23:0] TAG_READRESP     = 24'h735241;  // sRA
    localparam logic [23:0] TAG_WRITEVAR     = 24'h73574E;  // sWN
    localparam logic [23:0] TAG_WRITERESP    = 24'h735741;  // sWA
    localparam logic [23:0] TAG_METHOD       = 24'h734D4E;  // sMN
    localparam logic [23:0] TAG_METHODRETURN = 24'h73414E;  // sAN
    localparam logic [23:0] TAG_ERROR        = 24'h734641;  // sFA

    typedef enum logic [2:0] {
        CMD_UNKNOWN      = 3'd0,
        CMD_READVAR      = 3'd1,
        CMD_READRESP     = 3'd2,
        CMD_WRITEVAR     = 3'd3,
        CMD_WRITERESP    = 3'd4,
        CMD_METHOD       = 3'd5,
        CMD_METHODRETURN = 3'd6,
        CMD_ERROR        = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_DEV_ERROR = 2'd2,
        ST_RESERVED  = 2'd3
    } status_t;

    typedef enum logic [5:0] {
        PH_TYPE    = 6'b000001,
        PH_SPACE   = 6'b000010,
        PH_NAME    = 6'b000100,
        PH_CODE_HI = 6'b001000,
        PH_CODE_LO = 6'b010000,
        PH_DONE    = 6'b100000
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [POS_W-1:0]   pos;
        logic [7:0]         type_hi;
        logic [7:0]         type_lo;
        cmd_t               dtype;
        logic [7:0]         code_hi;
    } state_t;

    // Parser armed for the first type byte of a frame
    localparam state_t STATE_IDLE = '{phase: PH_TYPE, pos: '0, type_hi: '0, type_lo: '0,
                                      dtype: CMD_UNKNOWN, code_hi: '0};

    typedef struct packed {
        logic               valid;
        logic               kind;       // 0 name byte, 1 header result
        logic [7:0]         name_char;
        cmd_t               cmd;
        status_t            status;
        logic [15:0]        code;
        logic [POS_W-1:0]   offset;
    } result_t;

    function automatic cmd_t decode_type(input logic [23:0] tag);
        cmd_t c;
        case (tag)
            TAG_READVAR:      c = CMD_READVAR;
            TAG_READRESP:     c = CMD_READRESP;
            TAG_WRITEVAR:     c = CMD_WRITEVAR;
            TAG_WRITERESP:    c = CMD_WRITERESP;
            TAG_METHOD:       c = CMD_METHOD;
            TAG_METHODRETURN: c = CMD_METHODRETURN;
            TAG_ERROR:        c = CMD_ERROR;
            default:          c = CMD_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### design/chp_step.sv
// Per-byte header parsing step: next parser state and at most one result item.
// Purely combinational; depends on chp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chp_step #(
    parameter int unsigned MAX_FRAME_BYTES = chp_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire chp_pkg::state_t st,
    input  wire logic [7:0]      data_byte,
    input  wire logic            frame_last,
    output chp_pkg::state_t      st_next,
    output chp_pkg::result_t     res
);

    localparam logic [chp_pkg::POS_W-1:0] MAX_POS = chp_pkg::POS_W'(MAX_FRAME_BYTES);
    localparam logic [chp_pkg::POS_W-1:0] TYPE_LEN = chp_pkg::POS_W'(3);

    logic [chp_pkg::POS_W-1:0] new_pos;
    chp_pkg::cmd_t             typ;

    assign new_pos = (st.pos < MAX_POS) ? st.pos + 1'b1 : MAX_POS;
    assign typ     = chp_pkg::decode_type({st.type_hi, st.type_lo, data_byte});

    always_comb begin
        st_next = st;
        res     = '0;

        unique case (st.phase)
            chp_pkg::PH_TYPE: begin
                if (st.pos == '0) begin
                    st_next.type_hi = data_byte;
                end else if (st.pos == chp_pkg::POS_W'(1)) begin
                    st_next.type_lo = data_byte;
                end else begin
                    st_next.dtype = typ;
                    if (typ == chp_pkg::CMD_UNKNOWN) begin
                        res.valid     = 1'b1;
                        res.kind      = 1'b1;
                        res.status    = chp_pkg::ST_MALFORMED;
                        st_next.phase = chp_pkg::PH_DONE;
                    end else if (typ == chp_pkg::CMD_ERROR) begin
                        st_next.phase = chp_pkg::PH_CODE_HI;
                    end else begin
                        st_next.phase = chp_pkg::PH_SPACE;
                    end
                end
            end
            chp_pkg::PH_SPACE: begin
                if (data_byte == chp_pkg::CHAR_SPACE) begin
                    st_next.phase = chp_pkg::PH_NAME;
                end else begin
                    res.valid     = 1'b1;
                    res.kind      = 1'b1;
                    res.status    = chp_pkg::ST_MALFORMED;
                    res.offset    = TYPE_LEN;
                    st_next.phase = chp_pkg::PH_DONE;
                end
            end
            chp_pkg::PH_NAME: begin
                if (data_byte == chp_pkg::CHAR_SPACE) begin
                    res.valid     = 1'b1;
                    res.kind      = 1'b1;
                    res.cmd       = st.dtype;
                    res.status    = chp_pkg::ST_OK;
                    res.offset    = new_pos;
                    st_next.phase = chp_pkg::PH_DONE;
                end else if (!frame_last) begin
                    // echo name byte; the consumer drops it if the header fails
                    res.valid     = 1'b1;
                    res.name_char = data_byte;
                end
            end
            chp_pkg::PH_CODE_HI: begin
                st_next.code_hi = data_byte;
                st_next.phase   = chp_pkg::PH_CODE_LO;
            end
            chp_pkg::PH_CODE_LO: begin
                res.valid     = 1'b1;
                res.kind      = 1'b1;
                res.cmd       = chp_pkg::CMD_ERROR;
                res.status    = chp_pkg::ST_DEV_ERROR;
                res.code      = {st.code_hi, data_byte};
                res.offset    = TYPE_LEN;
                st_next.phase = chp_pkg::PH_DONE;
            end
            chp_pkg::PH_DONE: begin
                // drop trailing bytes until the frame ends
            end
            default: begin
            end
        endcase

        st_next.pos = new_pos;

        if (frame_last) begin
            // frame ended before a header result: report it malformed
            if (st_next.phase != chp_pkg::PH_DONE) begin
                res           = '0;
                res.valid     = 1'b1;
                res.kind      = 1'b1;
                res.status    = chp_pkg::ST_MALFORMED;
                if (st_next.phase == chp_pkg::PH_TYPE) begin
                    res.offset = '0;
                end else if (st_next.phase == chp_pkg::PH_CODE_HI ||
                             st_next.phase == chp_pkg::PH_CODE_LO) begin
                    res.offset = TYPE_LEN;
                end else begin
                    res.offset = new_pos;
                end
            end
            st_next = chp_pkg::STATE_IDLE;
        end
    end

endmodule

`default_nettype wire

### design/command_header_parser.sv
// Command header parser top level: input register, parse step, result register.
// Depends on chp_pkg and chp_step.
//
//  channel | dir | ports                       | payload
//  --------+-----+-----------------------------+-----------------------------------
//  input   | in  | s_tvalid s_tready s_tdata   | data_byte; s_tlast = frame_last
//  result  | out | m_tvalid m_tready m_tdata   | see m_tdata; m_tuser = result_kind
//
// One byte per cycle sustained while results are taken; a result passes from its byte
// through the input register and then the result register before it shows on m_tvalid.
// Reset clears both stage valids and rearms the parser at the first type byte.
// While a result waits on m_tready the input register holds and s_tready drops
// once it is full; bytes that yield no result wait behind it as well.
`timescale 1ns / 1ps
`default_nettype none

module command_header_parser #(
    parameter int unsigned MAX_FRAME_BYTES = chp_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // frame_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] name_char, [10:8] command_type, [12:11] parse_status,
    // [28:13] error_code, [44:29] param_offset, [47:45] zero
    output logic [47:0]      m_tdata,
    output logic             m_tuser    // result_kind
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_data_reg,  in_data_next;
    logic             in_last_reg,  in_last_next;
    logic             out_valid_reg, out_valid_next;
    chp_pkg::result_t out_res_reg,  out_res_next;
    chp_pkg::state_t  st_reg;
    chp_pkg::state_t  st_next;
    chp_pkg::result_t step_res;
    logic             advance;

    chp_step #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_step (
        .st        (st_reg),
        .data_byte (in_data_reg),
        .frame_last(in_last_reg),
        .st_next   (st_next),
        .res       (step_res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        in_last_next  = in_last_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_data_next  = s_tdata;
            in_last_next  = s_tlast;
        end

        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (advance) begin
            out_valid_next = step_res.valid;
            out_res_next   = step_res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= chp_pkg::STATE_IDLE;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                st_reg <= st_next;
            end
        end
        in_data_reg <= in_data_next;
        in_last_reg <= in_last_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tdata  = {3'b000, out_res_reg.offset, out_res_reg.code,
                       out_res_reg.status, out_res_reg.cmd, out_res_reg.name_char};

    // name-byte items carry nothing but the byte
    a_name_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[44:8] == '0)
        else $error("name-byte item carries header fields");

    // an ok header always names one of the six named types
    a_ok_named: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && out_res_reg.status == chp_pkg::ST_OK
        |-> out_res_reg.cmd != chp_pkg::CMD_UNKNOWN && out_res_reg.cmd != chp_pkg::CMD_ERROR)
        else $error("ok header without a named type");

    // a device error code comes only with the error type at offset three
    a_dev_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res_reg.status == chp_pkg::ST_DEV_ERROR
        |-> m_tuser && out_res_reg.cmd == chp_pkg::CMD_ERROR && out_res_reg.offset == 16'd3)
        else $error("device error result malformed");

    // the last byte of a frame rearms the parser
    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> st_reg.phase == chp_pkg::PH_TYPE && st_reg.pos == '0)
        else $error("parser not rearmed after frame end");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("stages not empty after reset");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking bench for command_header_parser: frames of telegram bytes in, echoed
// name bytes and header results out, each compared with a cycle-free predictor.
// Depends on chp_pkg and the command_header_parser RTL.
`timescale 1ns / 1ps

module testbench;
    import chp_pkg::*;

    localparam int          HALF_PERIOD = 5;
    localparam int unsigned FRAME_CAP   = MAX_FRAME_BYTES_DEF;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          TOTAL_ITEMS = 1850;
    localparam int          LONG_NAME_BYTES = 40;

    localparam logic [23:0] NAMED_TAGS [6] = '{TAG_READVAR, TAG_READRESP, TAG_WRITEVAR,
                                               TAG_WRITERESP, TAG_METHOD, TAG_METHODRETURN};

    // Layout of m_tdata, lowest field last
    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] offset;
        logic [15:0] code;
        status_t     status;
        cmd_t        cmd;
        logic [7:0]  name_char;
    } header_word_t;

    typedef struct packed {
        logic         kind;
        header_word_t word;
    } header_out_t;

    class header_tracker;
        phase_t      phase;
        int unsigned position;
        logic [7:0]  tag_hi;
        logic [7:0]  tag_lo;
        logic [7:0]  code_hi;
        cmd_t        named_cmd;
        header_out_t awaited[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            rewind();
        endfunction

        function void rewind();
            phase = PH_TYPE;
            position = 0;
            tag_hi = '0;
            tag_lo = '0;
            code_hi = '0;
            named_cmd = CMD_UNKNOWN;
        endfunction

        function cmd_t tag_to_cmd(logic [23:0] tag);
            case (tag)
                TAG_READVAR:      return CMD_READVAR;
                TAG_READRESP:     return CMD_READRESP;
                TAG_WRITEVAR:     return CMD_WRITEVAR;
                TAG_WRITERESP:    return CMD_WRITERESP;
                TAG_METHOD:       return CMD_METHOD;
                TAG_METHODRETURN: return CMD_METHODRETURN;
                TAG_ERROR:        return CMD_ERROR;
                default:          return CMD_UNKNOWN;
            endcase
        endfunction

        function void push(logic kind, logic [7:0] ch, cmd_t c, status_t s,
                           logic [15:0] code, logic [15:0] off);
            header_out_t e;
            e.kind = kind;
            e.word.pad = '0;
            e.word.name_char = ch;
            e.word.cmd = c;
            e.word.status = s;
            e.word.code = code;
            e.word.offset = off;
            awaited.insert(awaited.size(), e);
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            int unsigned nxt;
            logic [15:0] tail_off;
            nxt = (position < FRAME_CAP) ? position + 1 : FRAME_CAP;
            case (phase)
                PH_TYPE: begin
                    if (position == 0) begin
                        tag_hi = b;
                    end else if (position == 1) begin
                        tag_lo = b;
                    end else begin
                        named_cmd = tag_to_cmd({tag_hi, tag_lo, b});
                        if (named_cmd == CMD_UNKNOWN) begin
                            push(1'b1, 8'h00, CMD_UNKNOWN, ST_MALFORMED, 16'd0, 16'd0);
                            phase = PH_DONE;
                        end else if (named_cmd == CMD_ERROR) begin
                            phase = PH_CODE_HI;
                        end else begin
                            phase = PH_SPACE;
                        end
                    end
                end
                PH_SPACE: begin
                    if (b == CHAR_SPACE) begin
                        phase = PH_NAME;
                    end else begin
                        push(1'b1, 8'h00, CMD_UNKNOWN, ST_MALFORMED, 16'd0, 16'd3);
                        phase = PH_DONE;
                    end
                end
                PH_NAME: begin
                    if (b == CHAR_SPACE) begin
                        push(1'b1, 8'h00, named_cmd, ST_OK, 16'd0, nxt[15:0]);
                        phase = PH_DONE;
                    end else if (!last) begin
                        push(1'b0, b, CMD_UNKNOWN, ST_OK, 16'd0, 16'd0);
                    end
                end
                PH_CODE_HI: begin
                    code_hi = b;
                    phase = PH_CODE_LO;
                end
                PH_CODE_LO: begin
                    push(1'b1, 8'h00, CMD_ERROR, ST_DEV_ERROR, {code_hi, b}, 16'd3);
                    phase = PH_DONE;
                end
                default: ;
            endcase
            position = nxt;
            // A frame that ends before its header completed still owes one result
            if (last) begin
                if (phase != PH_DONE) begin
                    case (phase) inside
                        PH_TYPE:                tail_off = 16'd0;
                        PH_CODE_HI, PH_CODE_LO: tail_off = 16'd3;
                        default:                tail_off = nxt[15:0];
                    endcase
                    push(1'b1, 8'h00, CMD_UNKNOWN, ST_MALFORMED, 16'd0, tail_off);
                end
                rewind();
            end
        endfunction

        function void complain(string what, header_out_t want, logic kind, header_word_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t %s: expected kind=%0d char=%h cmd=%0d st=%0d code=%h off=%0d pad=%0d",
                         $realtime, what, want.kind, want.word.name_char, want.word.cmd,
                         want.word.status, want.word.code, want.word.offset, want.word.pad);
                $display("    got kind=%0d char=%h cmd=%0d st=%0d code=%h off=%0d pad=%0d",
                         kind, got.name_char, got.cmd, got.status, got.code, got.offset,
                         got.pad);
            end
        endfunction

        function void check_result(logic [47:0] data, logic kind);
            header_word_t got;
            header_out_t  want;
            got = data;
            if (awaited.size() == 0) begin
                want = '0;
                complain("result with nothing awaited", want, kind, got);
                return;
            end
            want = awaited.pop_front();
            if (kind !== want.kind || got.name_char !== want.word.name_char ||
                got.cmd !== want.word.cmd || got.status !== want.word.status ||
                got.code !== want.word.code || got.offset !== want.word.offset ||
                got.pad !== want.word.pad)
                complain("result mismatch", want, kind, got);
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;

    header_tracker sb = new();
    int          burst_left = 0;
    bit          hold_request = 1'b0;
    int unsigned cycle_count = 0;
    int          items_sent = 0;

    command_header_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b, last);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic [7:0] f[$]);
        foreach (f[i])
            send_byte(f[i], i == f.size() - 1);
    endtask

    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_SPACE);
        return b;
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed headers with random content; the rest broken in every way
    task automatic random_frame();
        logic [7:0]  f[$];
        logic [23:0] tag;
        int          pick;
        int          n;
        pick = $urandom_range(0, 99);
        tag = NAMED_TAGS[$urandom_range(0, 5)];
        if (pick < 55) begin
            f = {tag[23:16], tag[15:8], tag[7:0], CHAR_SPACE};
            repeat ($urandom_range(0, 8)) f.insert(f.size(), name_byte());
            f.insert(f.size(), CHAR_SPACE);
        end else if (pick < 70) begin
            f = {TAG_ERROR[23:16], TAG_ERROR[15:8], TAG_ERROR[7:0]};
            f.insert(f.size(), any_byte());
            f.insert(f.size(), any_byte());
        end else if (pick < 76) begin
            if ($urandom_range(0, 1) == 0) begin
                tag = 24'($urandom());
            end else begin
                n = $urandom_range(0, 23);
                tag[n] = ~tag[n];
            end
            f = {tag[23:16], tag[15:8], tag[7:0]};
        end else if (pick < 80) begin
            f.insert(f.size(), ($urandom_range(0, 1) == 0) ? TAG_READVAR[23:16] : any_byte());
            if ($urandom_range(0, 1) == 0) f.insert(f.size(), any_byte());
        end else if (pick < 86) begin
            f = {tag[23:16], tag[15:8], tag[7:0]};
            if ($urandom_range(0, 1) == 0) f.insert(f.size(), name_byte());
        end else if (pick < 93) begin
            f = {tag[23:16], tag[15:8], tag[7:0], CHAR_SPACE};
            repeat ($urandom_range(1, 6)) f.insert(f.size(), name_byte());
        end else begin
            f = {TAG_ERROR[23:16], TAG_ERROR[15:8], TAG_ERROR[7:0]};
            if ($urandom_range(0, 1) == 0) f.insert(f.size(), any_byte());
        end
        // Trailing bytes after a completed header are ignored by the block
        if (pick < 76)
            repeat ($urandom_range(0, 4)) f.insert(f.size(), any_byte());
        send_frame(f);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Receiver: ready runs broken by short stalls, one long hold-off on request
    initial begin
        int run;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (run) @(negedge aclk);
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [7:0] f[$];
        bit         held;
        bit         drained;
        held = 1'b0;
        drained = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: each way a header can end
        f = {TAG_READVAR[23:16], TAG_READVAR[15:8], TAG_READVAR[7:0], CHAR_SPACE,
             8'h61, CHAR_SPACE};
        send_frame(f);
        f = {TAG_ERROR[23:16], TAG_ERROR[15:8], TAG_ERROR[7:0], 8'hFF, 8'hFF};
        send_frame(f);
        f = {8'h00, 8'hFF, 8'h00};
        send_frame(f);
        f = {TAG_READVAR[23:16]};
        send_frame(f);
        f = {TAG_WRITEVAR[23:16], TAG_WRITEVAR[15:8], TAG_WRITEVAR[7:0]};
        send_frame(f);
        f = {TAG_METHOD[23:16], TAG_METHOD[15:8], TAG_METHOD[7:0], 8'h78};
        send_frame(f);
        f = {TAG_METHODRETURN[23:16], TAG_METHODRETURN[15:8], TAG_METHODRETURN[7:0],
             CHAR_SPACE, 8'hFF, 8'h00};
        send_frame(f);

        // Two longer names, one closed and one cut off by the frame end
        f = {TAG_READRESP[23:16], TAG_READRESP[15:8], TAG_READRESP[7:0], CHAR_SPACE};
        repeat (LONG_NAME_BYTES) f.insert(f.size(), name_byte());
        f.insert(f.size(), CHAR_SPACE);
        send_frame(f);
        f = {TAG_WRITERESP[23:16], TAG_WRITERESP[15:8], TAG_WRITERESP[7:0], CHAR_SPACE};
        repeat (LONG_NAME_BYTES) f.insert(f.size(), name_byte());
        send_frame(f);

        while (items_sent < TOTAL_ITEMS) begin
            if (!held && items_sent > TOTAL_ITEMS / 3) begin
                held = 1'b1;
                hold_request = 1'b1;
            end
            if (!drained && items_sent > (2 * TOTAL_ITEMS) / 3) begin
                drained = 1'b1;
                drain();
            end
            random_frame();
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
design/chp_pkg.sv
design/chp_step.sv
design/command_header_parser.sv
tb/sv/testbench.sv
